// ===== rtl/bcd_checksum_frame_engine_defines.svh =====
// Assertion macros used by the checker of the frame engine.
`ifndef BCD_CHECKSUM_FRAME_ENGINE_DEFINES_SVH
`define BCD_CHECKSUM_FRAME_ENGINE_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define BCFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, during reset as well.
`define BCFE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/bcfe_pkg.sv =====
package bcfe_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StationW = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned TxRunLen = 6;
  localparam int unsigned TxIdxW = 3;

  localparam logic [StationW-1:0] StationMax = 7'd99;
  localparam logic [ByteW-1:0] LenByte = 8'h04;
  localparam logic [ByteW-1:0] ShortMax = 8'd3;
  localparam logic [TxIdxW-1:0] TxLastIdx = 3'(TxRunLen - 1);

  // Output tdata layout, from the lowest bit up.
  localparam int unsigned OutTxLsb = 0;
  localparam int unsigned OutStatusLsb = 8;
  localparam int unsigned OutLenLsb = 11;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 3'd0,
    STS_STATION   = 3'd1,
    STS_LENGTH    = 3'd2,
    STS_CHECKSUM  = 3'd3,
    STS_TOO_SHORT = 3'd4,
    STS_BAD_REQ   = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_CHAR = 2'd0,
    CFG_END_CHAR   = 2'd1,
    CFG_CMD_ONE    = 2'd2,
    CFG_CMD_TWO    = 2'd3
  } cfg_idx_e;

  // Decimal value of a byte read as two BCD digits; up to 165.
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
  endfunction

  // Remainder by 100 for values below 400.
  function automatic logic [6:0] mod100(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (r >= 9'd300) begin
      r = r - 9'd300;
    end else if (r >= 9'd200) begin
      r = r - 9'd200;
    end else if (r >= 9'd100) begin
      r = r - 9'd100;
    end
    return r[6:0];
  endfunction

  // Two BCD digits of a value below 100.
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0] tens;
    logic [6:0] ones;
    p = {8'b0, v} * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens * 4'd10);
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] bcd_add(input logic [7:0] a, input logic [7:0] b);
    return bin_to_bcd(mod100({1'b0, bcd_dec(a)} + {1'b0, bcd_dec(b)}));
  endfunction

endpackage

// ===== rtl/bcd_checksum_frame_engine.sv =====
// Each accepted item waits in the input register; its result enters the output register once that is free.
// Throughput: one item per cycle while no result waits on a busy output register; a read
// request holds that register for all six transmit bytes, while bytes that end no frame keep flowing in.
// Reset: asynchronous, active low; control registers take their reset values, the receiver
// hunts for the start character and both stages are empty. No clearing pass is needed.
module bcd_checksum_frame_engine
  import bcfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // rx_byte[7:0], station[14:8], group[15]
  input  logic                s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // tx_byte[7:0], status[10:8], frame_length[18:11]
  output logic                m_axis_tuser,  // kind
  output logic                m_axis_tlast   // last
);

  logic [ByteW-1:0] start_char_q, end_char_q, cmd_one_q, cmd_two_q;

  logic                in_valid_q;
  logic                in_func_q;
  logic [ByteW-1:0]    in_rx_q;
  logic [StationW-1:0] in_station_q;
  logic                in_group_q;

  logic                collecting_q, collecting_d;
  logic [StationW-1:0] exp_station_q, exp_station_d;
  logic [ByteW-1:0]    count_q, count_d;
  logic [ByteW-1:0]    first_q, first_d;
  logic [ByteW-1:0]    second_q, second_d;
  logic [ByteW-1:0]    held_q, held_d;
  logic [ByteW-1:0]    sum_q, sum_d;

  logic                out_valid_q, out_valid_d;
  logic                out_kind_q, out_kind_d;
  logic [TxIdxW-1:0]   out_idx_q, out_idx_d;
  status_e             out_status_q, out_status_d;
  logic [ByteW-1:0]    out_len_q, out_len_d;
  logic [ByteW-1:0]    tx_q [TxRunLen];
  logic [ByteW-1:0]    tx_d [TxRunLen];

  logic    accept, consume, out_take, out_free, produces;
  logic    is_end, is_req_ok;
  status_e verdict;
  logic [ByteW-1:0] cmd_byte, station_bcd, req_sum;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_take = out_valid_q & m_axis_tready;
  assign out_free = ~out_valid_q | (out_take & (out_kind_q | (out_idx_q == TxLastIdx)));
  assign is_end   = ~in_func_q & collecting_q & (in_rx_q == end_char_q);
  assign produces = in_func_q | is_end;
  assign consume  = in_valid_q & (~produces | out_free);
  assign s_axis_tready = ~in_valid_q | consume;

  assign is_req_ok   = in_station_q <= StationMax;
  assign cmd_byte    = in_group_q ? cmd_two_q : cmd_one_q;
  assign station_bcd = bin_to_bcd(in_station_q);
  assign req_sum     = bin_to_bcd(mod100({2'b0, in_station_q} + {1'b0, LenByte} +
                                         {1'b0, bcd_dec(cmd_byte)}));

  always_comb begin
    if (count_q <= ShortMax) begin
      verdict = STS_TOO_SHORT;
    end else if (bcd_dec(first_q) != {1'b0, exp_station_q}) begin
      verdict = STS_STATION;
    end else if (bcd_dec(second_q) != count_q) begin
      verdict = STS_LENGTH;
    end else if (sum_q != held_q) begin
      verdict = STS_CHECKSUM;
    end else begin
      verdict = STS_OK;
    end
  end

  always_comb begin
    collecting_d  = collecting_q;
    exp_station_d = exp_station_q;
    count_d       = count_q;
    first_d       = first_q;
    second_d      = second_q;
    held_d        = held_q;
    sum_d         = sum_q;
    if (consume) begin
      if (in_func_q) begin
        if (is_req_ok) begin
          exp_station_d = in_station_q;
          collecting_d  = 1'b0;
          count_d       = '0;
          first_d       = '0;
          second_d      = '0;
          held_d        = '0;
          sum_d         = '0;
        end
      end else if (!collecting_q) begin
        if (in_rx_q == start_char_q) begin
          collecting_d = 1'b1;
          count_d      = '0;
          first_d      = '0;
          second_d     = '0;
          held_d       = '0;
          sum_d        = '0;
        end
      end else if (is_end) begin
        collecting_d = 1'b0;
        count_d      = '0;
        first_d      = '0;
        second_d     = '0;
        held_d       = '0;
        sum_d        = '0;
      end else begin
        if (count_q == 8'd0) begin
          first_d = in_rx_q;
        end else if (count_q == 8'd1) begin
          second_d = in_rx_q;
        end
        if (count_q != 8'd0) begin
          sum_d = bcd_add(sum_q, held_q);
        end
        held_d = in_rx_q;
        if (count_q != 8'hff) begin
          count_d = count_q + 8'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    tx_d         = tx_q;
    if (out_take) begin
      out_idx_d = out_idx_q + 3'd1;
      for (int i = 0; i < TxRunLen - 1; i++) begin
        tx_d[i] = tx_q[i+1];
      end
      if (out_free) begin
        out_valid_d = 1'b0;
      end
    end
    if (consume && produces) begin
      out_valid_d = 1'b1;
      out_idx_d   = '0;
      if (in_func_q && is_req_ok) begin
        out_kind_d   = 1'b0;
        out_status_d = STS_OK;
        out_len_d    = '0;
        tx_d[0]      = start_char_q;
        tx_d[1]      = station_bcd;
        tx_d[2]      = LenByte;
        tx_d[3]      = cmd_byte;
        tx_d[4]      = req_sum;
        tx_d[5]      = end_char_q;
      end else begin
        out_kind_d   = 1'b1;
        out_status_d = in_func_q ? STS_BAD_REQ : verdict;
        out_len_d    = in_func_q ? '0 : count_q;
        for (int i = 0; i < TxRunLen; i++) begin
          tx_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q  <= 8'd2;
      end_char_q    <= 8'd3;
      cmd_one_q     <= '0;
      cmd_two_q     <= '0;
      in_valid_q    <= 1'b0;
      collecting_q  <= 1'b0;
      exp_station_q <= '0;
      count_q       <= '0;
      first_q       <= '0;
      second_q      <= '0;
      held_q        <= '0;
      sum_q         <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= 1'b0;
      out_idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_START_CHAR: start_char_q <= cfg_wdata_i;
          CFG_END_CHAR:   end_char_q   <= cfg_wdata_i;
          CFG_CMD_ONE:    cmd_one_q    <= cfg_wdata_i;
          CFG_CMD_TWO:    cmd_two_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      collecting_q  <= collecting_d;
      exp_station_q <= exp_station_d;
      count_q       <= count_d;
      first_q       <= first_d;
      second_q      <= second_d;
      held_q        <= held_d;
      sum_q         <= sum_d;
      out_valid_q   <= out_valid_d;
      out_kind_q    <= out_kind_d;
      out_idx_q     <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_func_q    <= s_axis_tuser;
      in_rx_q      <= s_axis_tdata[7:0];
      in_station_q <= s_axis_tdata[14:8];
      in_group_q   <= s_axis_tdata[15];
    end
    out_status_q <= out_status_d;
    out_len_q    <= out_len_d;
    tx_q         <= tx_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = ~out_kind_q & (out_idx_q == TxLastIdx);
  assign m_axis_tdata  = {5'b0, out_len_q, out_status_q, tx_q[0]};

endmodule

// ===== rtl/bcfe_checker.sv =====
`include "bcd_checksum_frame_engine_defines.svh"

module bcfe_checker
  import bcfe_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  logic [StatusW-1:0]           out_status;
  logic [ByteW-1:0]             out_tx_byte;
  logic [OutDataW-OutStatusLsb-1:0] out_fields;
  logic [OutDataW+1:0]          out_item;
  logic                         out_stall;
  logic                         out_verdict;
  logic                         out_tx;

  assign out_status  = m_axis_tdata[OutStatusLsb +: StatusW];
  assign out_tx_byte = m_axis_tdata[OutTxLsb +: ByteW];
  assign out_fields  = m_axis_tdata[OutDataW-1:OutStatusLsb];
  assign out_item    = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign out_stall   = m_axis_tvalid & ~m_axis_tready;
  assign out_verdict = m_axis_tvalid & m_axis_tuser;
  assign out_tx      = m_axis_tvalid & ~m_axis_tuser;

  `BCFE_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_item), "Stalled item changed.")
  `BCFE_ASSERT(a_verdict_shape, out_verdict |-> !m_axis_tlast && out_tx_byte == '0, "Bad verdict.")
  `BCFE_ASSERT(a_status_range, out_verdict |-> out_status <= STS_BAD_REQ, "Bad verdict status.")
  `BCFE_ASSERT(a_tx_shape, out_tx |-> out_fields == '0, "Transmit item carries verdict fields.")
  `BCFE_ASSERT(a_run_continues, out_tx && m_axis_tready && !m_axis_tlast |=> out_tx, "Run broken.")
  `BCFE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "Output item valid during reset.")

endmodule

bind bcd_checksum_frame_engine bcfe_checker u_bcfe_checker (.*);

// ===== bench/tb_bcd_checksum_frame_engine.sv =====
module tb_bcd_checksum_frame_engine;
  import bcfe_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PhaseItems = 64;

  typedef enum int {
    FLAW_NONE,
    FLAW_STATION,
    FLAW_LENGTH,
    FLAW_CHECKSUM
  } frame_flaw_e;

  typedef struct packed {
    logic               kind;
    logic [ByteW-1:0]   tx;
    logic               last;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   len;
    logic [4:0]         pad;
  } frame_result_t;

  class link_frame_model;
    logic [ByteW-1:0]    start_char;
    logic [ByteW-1:0]    end_char;
    logic [ByteW-1:0]    cmd_one;
    logic [ByteW-1:0]    cmd_two;
    bit                  collecting;
    logic [StationW-1:0] exp_station;
    logic [ByteW-1:0]    count;
    logic [ByteW-1:0]    first_b;
    logic [ByteW-1:0]    second_b;
    logic [ByteW-1:0]    held_b;
    logic [ByteW-1:0]    sum_b;
    frame_result_t       pending_results[$];
    int unsigned         errors;
    int unsigned         tx_bytes;
    int unsigned         verdicts;

    function new();
      start_char = 8'h02;
      end_char = 8'h03;
      cmd_one = 8'h00;
      cmd_two = 8'h00;
      exp_station = '0;
      errors = 0;
      tx_bytes = 0;
      verdicts = 0;
      clear_rx();
    endfunction

    static function int bcd_val(logic [ByteW-1:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    static function logic [ByteW-1:0] to_bcd(int v);
      return {4'(v / 10), 4'(v % 10)};
    endfunction

    static function logic [ByteW-1:0] bcd_add(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
      return to_bcd((bcd_val(a) + bcd_val(b)) % 100);
    endfunction

    function void clear_rx();
      collecting = 1'b0;
      count = '0;
      first_b = '0;
      second_b = '0;
      held_b = '0;
      sum_b = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [ByteW-1:0] v);
      case (idx)
        CFG_START_CHAR: start_char = v;
        CFG_END_CHAR:   end_char = v;
        CFG_CMD_ONE:    cmd_one = v;
        default:        cmd_two = v;
      endcase
    endfunction

    function void push(bit kind, logic [ByteW-1:0] tx, bit last, status_e st,
                       logic [ByteW-1:0] len);
      frame_result_t r;
      r.kind = kind;
      r.tx = tx;
      r.last = last;
      r.status = st;
      r.len = len;
      r.pad = '0;
      pending_results = {pending_results, r};
    endfunction

    function void accept_item(bit func, logic [ByteW-1:0] rx, logic [StationW-1:0] st,
                              bit grp);
      logic [ByteW-1:0] run[TxRunLen];
      status_e verdict;
      if (func) begin
        if (st > 7'd99) begin
          push(1'b1, '0, 1'b0, STS_BAD_REQ, '0);
        end else begin
          run[0] = start_char;
          run[1] = to_bcd(int'(st));
          run[2] = 8'h04;
          run[3] = grp ? cmd_two : cmd_one;
          run[4] = bcd_add(bcd_add(bcd_add(8'h00, run[1]), run[2]), run[3]);
          run[5] = end_char;
          for (int i = 0; i < TxRunLen; i++) begin
            push(1'b0, run[i], i == TxRunLen - 1, STS_OK, '0);
          end
          exp_station = st;
          clear_rx();
        end
      end else if (!collecting) begin
        if (rx == start_char) begin
          clear_rx();
          collecting = 1'b1;
        end
      end else if (rx == end_char) begin
        if (count <= 8'd3) begin
          verdict = STS_TOO_SHORT;
        end else if (bcd_val(first_b) != int'(exp_station)) begin
          verdict = STS_STATION;
        end else if (bcd_val(second_b) != int'(count)) begin
          verdict = STS_LENGTH;
        end else if (sum_b != held_b) begin
          verdict = STS_CHECKSUM;
        end else begin
          verdict = STS_OK;
        end
        push(1'b1, '0, 1'b0, verdict, count);
        clear_rx();
      end else begin
        if (count == 8'd0) begin
          first_b = rx;
        end else if (count == 8'd1) begin
          second_b = rx;
        end
        if (count != 8'd0) begin
          sum_b = bcd_add(sum_b, held_b);
        end
        held_b = rx;
        if (count != 8'hff) begin
          count++;
        end
      end
    endfunction

    function void compare_result(logic kind, logic [OutDataW-1:0] data, logic last);
      frame_result_t want;
      frame_result_t got;
      got.kind = kind;
      got.tx = data[7:0];
      got.status = data[10:8];
      got.len = data[18:11];
      got.pad = data[23:19];
      got.last = last;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d tdata=%h last=%0d",
                 $time, kind, data, last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d tx=%h last=%0d status=%0d len=%0d pad=%h",
                   $time, want.kind, want.tx, want.last, want.status, want.len, want.pad);
          $display("%0t:          actual   kind=%0d tx=%h last=%0d status=%0d len=%0d pad=%h",
                   $time, got.kind, got.tx, got.last, got.status, got.len, got.pad);
        end else if (kind) begin
          verdicts++;
        end else begin
          tx_bytes++;
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [ByteW-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  link_frame_model model = new();
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_request;
  bit          hold_done;

  bcd_checksum_frame_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               model.pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      model.compare_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // The long hold-off is counted here so the sender keeps offering items meanwhile.
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input bit func, input logic [ByteW-1:0] rx,
                           input logic [StationW-1:0] st, input bit grp);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser = func;
    s_axis_tdata = {grp, st, rx};
    s_axis_tvalid = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    model.accept_item(func, rx, st, grp);
    items_sent++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    send_item(1'b0, b, 7'($urandom_range(127)), 1'($urandom_range(1)));
  endtask

  task automatic send_request(input logic [StationW-1:0] st, input bit grp);
    send_item(1'b1, 8'($urandom_range(255)), st, grp);
  endtask

  task automatic send_frame(input int n, input frame_flaw_e flaw);
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int tries;
    bit clash;
    tries = 0;
    do begin
      body.delete();
      sum = 8'h00;
      clash = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (i == 0) begin
          b = link_frame_model::to_bcd(flaw == FLAW_STATION ?
                                       (int'(model.exp_station) + 1) % 100 :
                                       int'(model.exp_station));
        end else if (i == 1) begin
          b = link_frame_model::to_bcd(flaw == FLAW_LENGTH ? (n + 1) % 100 : n % 100);
        end else if (i == n - 1) begin
          b = (flaw == FLAW_CHECKSUM) ? (sum ^ 8'h10) : sum;
        end else begin
          b = 8'($urandom_range(255));
        end
        if (i != n - 1) begin
          sum = link_frame_model::bcd_add(sum, b);
        end
        if (b == model.end_char) begin
          clash = 1'b1;
        end
        body = {body, b};
      end
      tries++;
    end while (clash && tries < 16);
    send_byte(model.start_char);
    foreach (body[i]) begin
      send_byte(body[i]);
    end
    send_byte(model.end_char);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ByteW-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    model.set_reg(idx, v);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (model.pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned base;
    int pick;
    int k;
    frame_flaw_e flaw;
    base = items_sent;
    while (items_sent - base < quota) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        if ($urandom_range(9) == 0) begin
          send_request(7'($urandom_range(100, 127)), 1'($urandom_range(1)));
        end else begin
          send_request(7'($urandom_range(99)), 1'($urandom_range(1)));
        end
      end else if (pick < 17) begin
        send_byte(model.start_char);
        k = $urandom_range(1, 5);
        repeat (k) send_byte(8'($urandom_range(255)));
      end else if (pick < 27) begin
        k = $urandom_range(1, 3);
        repeat (k) send_byte(8'($urandom_range(255)));
      end else if (pick < 35) begin
        send_byte(model.start_char);
        k = $urandom_range(0, 3);
        repeat (k) send_byte(8'($urandom_range(255)));
        send_byte(model.end_char);
      end else begin
        k = $urandom_range(9);
        flaw = (k < 7) ? FLAW_NONE : frame_flaw_e'(k - 6);
        send_frame($urandom_range(4, 10), flaw);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CFG_START_CHAR;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    hold_request = 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 74;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(7'd0, 1'b0);
    send_request(7'd99, 1'b1);
    send_request(7'd100, 1'b0);
    send_request(7'd127, 1'b1);
    send_request(7'd12, 1'b0);
    // A start character inside a frame is ordinary data.
    send_byte(8'h02);
    send_byte(8'h12);
    send_byte(8'h05);
    send_byte(8'h02);
    send_byte(8'h02);
    send_byte(8'h21);
    send_byte(8'h03);
    send_byte(8'h02);
    send_byte(8'h12);
    send_byte(8'h04);
    send_byte(8'h16);
    send_byte(8'h03);
    send_frame(4, FLAW_STATION);
    run_random(PhaseItems);
    settle();

    write_reg(CFG_START_CHAR, 8'h00);
    write_reg(CFG_END_CHAR, 8'hff);
    write_reg(CFG_CMD_ONE, 8'hff);
    write_reg(CFG_CMD_TWO, 8'h00);
    tx_idle_pct = 74;
    rx_idle_pct = 8;
    send_request(7'($urandom_range(99)), 1'b0);
    send_frame(12, FLAW_NONE);
    run_random(PhaseItems);
    settle();

    write_reg(CFG_START_CHAR, 8'h7e);
    write_reg(CFG_END_CHAR, 8'h7e);
    write_reg(CFG_CMD_ONE, 8'($urandom_range(255)));
    write_reg(CFG_CMD_TWO, 8'($urandom_range(255)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    repeat (4) send_request(7'($urandom_range(99)), 1'($urandom_range(1)));
    run_random(PhaseItems);
    settle();

    if (model.pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               model.pending_results.size());
      model.errors++;
    end
    $display("Sent %0d items under three register settings and three idle patterns.",
             items_sent);
    $display("Checked %0d transmit bytes and %0d frame verdicts, %0d mismatches.",
             model.tx_bytes, model.verdicts, model.errors);
    if (model.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bcfe_pkg.sv
rtl/bcd_checksum_frame_engine.sv
rtl/bcfe_checker.sv
bench/tb_bcd_checksum_frame_engine.sv
